// File: sv/great_circle_range_bearing_defines.svh
// ============================================================================
// Great-circle range and bearing: assertion macros
// Shared concurrent assertion forms for the checker of the block.
// ============================================================================
`ifndef GREAT_CIRCLE_RANGE_BEARING_DEFINES_SVH
`define GREAT_CIRCLE_RANGE_BEARING_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define GCRB_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define GCRB_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/gcrb_pkg.sv
// ============================================================================
// Great-circle range and bearing: package
// Datapath types, turn constants and elaboration-time CORDIC constants.
// ============================================================================
`default_nettype none

package gcrb_pkg;

  typedef logic signed [63:0] dp_t;
  typedef logic [63:0]        turn_t;
  typedef logic signed [31:0] q30_t;

  localparam dp_t   Q_ONE          = 64'sh0000_0000_4000_0000;
  localparam turn_t D_ONE          = 64'h1000_0000_0000_0000;
  localparam turn_t TURN_HALF      = 64'h8000_0000_0000_0000;
  localparam turn_t TURN_QUARTER   = 64'h4000_0000_0000_0000;
  localparam turn_t PI_QUARTER_Q64 = 64'hC90F_DAA2_2168_C234;
  localparam turn_t INV_TWO_PI_Q64 = 64'h28BE_60DB_9391_054A;

  function automatic turn_t mul_q60(input turn_t a, input turn_t b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // Unsigned quotient by shift and subtract, used for table constants only.
  function automatic turn_t udiv64(input turn_t num, input turn_t den);
    turn_t quo;
    turn_t rem;
    int    b;
    quo = '0;
    rem = '0;
    for (b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Arctangent of 2^-i as a fraction of a turn, Q0.64.
  function automatic turn_t atan_turn(input int i);
    turn_t        rad;
    turn_t        t;
    logic [127:0] p;
    int           k;
    rad = '0;
    if (i == 0) begin
      rad = PI_QUARTER_Q64;
    end else begin
      for (k = 0; i * (2 * k + 1) < 64; k++) begin
        t = udiv64(64'd1 << (64 - i * (2 * k + 1)), turn_t'(2 * k + 1));
        if (k % 2 == 1) begin
          rad = rad - t;
        end else begin
          rad = rad + t;
        end
      end
    end
    p = {64'd0, rad} * {64'd0, INV_TWO_PI_Q64};
    return p[127:64];
  endfunction

  // Reciprocal of the CORDIC gain, Q4.60, by Newton iteration.
  function automatic dp_t gain_comp(input int stages);
    turn_t p;
    turn_t y;
    turn_t t;
    int    i;
    p = D_ONE;
    for (i = 0; i < stages; i++) begin
      if (2 * i < 64) begin
        p = p + (p >> (2 * i));
      end
    end
    y = (D_ONE / 64'd10) * 64'd6;
    for (i = 0; i < 8; i++) begin
      t = mul_q60(p, mul_q60(y, y));
      y = mul_q60(y, 64'd3 * D_ONE - t) >> 1;
    end
    return dp_t'(y);
  endfunction

endpackage

`default_nettype wire

// File: sv/gcrb_in_if.sv
// ============================================================================
// Great-circle range and bearing: position pair channel
// Valid/ready channel carrying an origin and a target position.
// ============================================================================
`default_nettype none

interface gcrb_in_if #(
  parameter int ANGLE_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [ANGLE_BITS-1:0] from_longitude;
  logic signed [ANGLE_BITS-1:0] from_latitude;
  logic signed [ANGLE_BITS-1:0] to_longitude;
  logic signed [ANGLE_BITS-1:0] to_latitude;

  modport source (
    output valid, from_longitude, from_latitude, to_longitude, to_latitude,
    input  ready
  );
  modport sink (
    input  valid, from_longitude, from_latitude, to_longitude, to_latitude,
    output ready
  );
endinterface

`default_nettype wire

// File: sv/gcrb_out_if.sv
// ============================================================================
// Great-circle range and bearing: result channel
// Valid/ready channel carrying distance, bearing and the undefined flag.
// ============================================================================
`default_nettype none

interface gcrb_out_if #(
  parameter int ANGLE_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic [ANGLE_BITS-1:0] arc_distance;
  logic [ANGLE_BITS-1:0] bearing;
  logic                  undefined_bearing;

  modport source (
    output valid, arc_distance, bearing, undefined_bearing,
    input  ready
  );
  modport sink (
    input  valid, arc_distance, bearing, undefined_bearing,
    output ready
  );
endinterface

`default_nettype wire

// File: sv/gcrb_cordic.sv
// ============================================================================
// Great-circle range and bearing: pipelined CORDIC
// One micro-rotation per register stage, rotation or vectoring mode.
// ============================================================================
`default_nettype none

module gcrb_cordic
  import gcrb_pkg::*;
#(
  parameter int STAGES    = 30,
  parameter bit VECTORING = 1'b0
) (
  input  wire logic  clk_i,
  input  wire logic  en_i,
  input  wire dp_t   x_i,
  input  wire dp_t   y_i,
  input  wire turn_t z_i,
  output dp_t        x_o,
  output dp_t        y_o,
  output turn_t      z_o
);

  dp_t   x_q [STAGES];
  dp_t   y_q [STAGES];
  turn_t z_q [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam turn_t ATAN = atan_turn(i);
    dp_t   x_in;
    dp_t   y_in;
    turn_t z_in;
    logic  sel;

    if (i == 0) begin : g_first
      assign x_in = x_i;
      assign y_in = y_i;
      assign z_in = z_i;
    end else begin : g_next
      assign x_in = x_q[i-1];
      assign y_in = y_q[i-1];
      assign z_in = z_q[i-1];
    end

    assign sel = VECTORING ? ~y_in[63] : z_in[63];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (sel) begin
          x_q[i] <= x_in + (y_in >>> i);
          y_q[i] <= y_in - (x_in >>> i);
          z_q[i] <= z_in + ATAN;
        end else begin
          x_q[i] <= x_in - (y_in >>> i);
          y_q[i] <= y_in + (x_in >>> i);
          z_q[i] <= z_in - ATAN;
        end
      end
    end
  end

  assign x_o = x_q[STAGES-1];
  assign y_o = y_q[STAGES-1];
  assign z_o = z_q[STAGES-1];

endmodule

`default_nettype wire

// File: sv/great_circle_range_bearing.sv
// ============================================================================
// Great-circle range and bearing
// Central angle by the spherical law of cosines and initial bearing by
// arcsine, on pipelined CORDIC, square-root and divider stages.
// ============================================================================
//
// Channel | Direction | Contents
// in_i    | sink      | from/to longitude and latitude, binary angles
// out_o   | source    | arc_distance, bearing, undefined_bearing
//
// One transaction is taken every cycle while the output is not stalled; the
// sine/cosine chain, the first square root, the divider, the second square
// root and the arctangent chain lie in series.
// Reset clears only the valid bits of the pipeline.
// When a result is not taken, the whole pipeline holds and in_i.ready drops.
`default_nettype none

module great_circle_range_bearing
  import gcrb_pkg::*;
#(
  parameter int ANGLE_BITS    = 32,
  parameter int CORDIC_STAGES = 30
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  gcrb_in_if.sink   in_i,
  gcrb_out_if.source out_o
);

  localparam int  SH      = 64 - ANGLE_BITS;
  localparam int  C       = CORDIC_STAGES;
  localparam int  LAT     = 2 * C + 109;
  localparam int  SQ      = 32;
  localparam int  DV      = 31;
  localparam int  DLY_A   = 67;
  localparam int  DLY_S0  = C + 39;
  localparam int  DLY_S1  = C + 68;
  localparam int  DLY_Q   = 34;
  localparam dp_t GAIN    = gain_comp(CORDIC_STAGES);

  typedef struct packed {
    turn_t v;
    turn_t r;
  } sq_t;

  function automatic q30_t to_q30(input dp_t v);
    dp_t r;
    r = (v + 64'sd536870912) >>> 30;
    if (r > Q_ONE) begin
      r = Q_ONE;
    end
    if (r < -Q_ONE) begin
      r = -Q_ONE;
    end
    return signed'(r[31:0]);
  endfunction

  function automatic sq_t sq_step(input sq_t s, input int k);
    sq_t   o;
    turn_t b;
    b = 64'd1 << (62 - 2 * k);
    if (s.v >= s.r + b) begin
      o.v = s.v - (s.r + b);
      o.r = (s.r >> 1) + b;
    end else begin
      o.v = s.v;
      o.r = s.r >> 1;
    end
    return o;
  endfunction

  function automatic logic [ANGLE_BITS-1:0] to_ba(input turn_t t);
    logic [ANGLE_BITS+1:0] r;
    r = (ANGLE_BITS+2)'(t >> (SH - 1)) + 1'b1;
    return r[ANGLE_BITS:1];
  endfunction

  logic adv;
  logic [LAT-1:0] vld_q;

  assign adv        = ~vld_q[LAT-1] | out_o.ready;
  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], in_i.valid};
    end
  end

  // Input stage: binary angles to turns and quadrant folding.
  turn_t lat1_t, lat2_t, lng1_t, lng2_t;
  turn_t th_d [3];
  logic  [2:0] flip_d;
  turn_t th_q [3];
  logic  [2:0] flip_q;
  logic  south_q;

  assign lng1_t = {in_i.from_longitude, {SH{1'b0}}};
  assign lat1_t = {in_i.from_latitude, {SH{1'b0}}};
  assign lng2_t = {in_i.to_longitude, {SH{1'b0}}};
  assign lat2_t = {in_i.to_latitude, {SH{1'b0}}};

  always_comb begin
    turn_t raw [3];
    raw[0] = lat1_t;
    raw[1] = lat2_t;
    raw[2] = lng2_t - lng1_t;
    for (int j = 0; j < 3; j++) begin
      turn_t s;
      s         = raw[j] + TURN_QUARTER;
      flip_d[j] = s[63];
      th_d[j]   = s[63] ? raw[j] - TURN_HALF : raw[j];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      th_q    <= th_d;
      flip_q  <= flip_d;
      south_q <= (lat2_t ^ TURN_HALF) < (lat1_t ^ TURN_HALF);
    end
  end

  // Sine and cosine of both latitudes and of the longitude difference.
  dp_t   rx [3];
  dp_t   ry [3];
  turn_t rz [3];

  for (genvar j = 0; j < 3; j++) begin : g_rot
    gcrb_cordic #(
      .STAGES    (CORDIC_STAGES),
      .VECTORING (1'b0)
    ) u_rot (
      .clk_i (clk_i),
      .en_i  (adv),
      .x_i   (GAIN),
      .y_i   ('0),
      .z_i   (th_q[j]),
      .x_o   (rx[j]),
      .y_o   (ry[j]),
      .z_o   (rz[j])
    );
  end

  logic [2:0] flip_dl_q [C];
  logic       south_dl_q [DLY_S0];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      flip_dl_q[0]  <= flip_q;
      south_dl_q[0] <= south_q;
      for (int k = 1; k < C; k++) begin
        flip_dl_q[k] <= flip_dl_q[k-1];
      end
      for (int k = 1; k < DLY_S0; k++) begin
        south_dl_q[k] <= south_dl_q[k-1];
      end
    end
  end

  // Law of cosines.
  q30_t sl1_q, cl1_q, sl2_q, cl2_q, sa_q, ca_q;
  q30_t ca1_q, ca2_q, tcc_q, cosd3_q, cosd4_q, cosd5_q;
  dp_t  pss1_q, pcc1_q, pcs1_q, pss2_q, pcs2_q, pss3_q, pcs3_q, pcca_q;
  dp_t  pcs4_q, pcs5_q, pcs6_q, csq_q;
  turn_t rad_q;
  logic [2:0] fl;

  assign fl = flip_dl_q[C-1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cl1_q   <= fl[0] ? -to_q30(rx[0]) : to_q30(rx[0]);
      sl1_q   <= fl[0] ? -to_q30(ry[0]) : to_q30(ry[0]);
      cl2_q   <= fl[1] ? -to_q30(rx[1]) : to_q30(rx[1]);
      sl2_q   <= fl[1] ? -to_q30(ry[1]) : to_q30(ry[1]);
      ca_q    <= fl[2] ? -to_q30(rx[2]) : to_q30(rx[2]);
      sa_q    <= fl[2] ? -to_q30(ry[2]) : to_q30(ry[2]);

      pss1_q  <= dp_t'(sl2_q) * dp_t'(sl1_q);
      pcc1_q  <= dp_t'(cl2_q) * dp_t'(cl1_q);
      pcs1_q  <= dp_t'(cl2_q) * dp_t'(sa_q);
      ca1_q   <= ca_q;

      tcc_q   <= to_q30(pcc1_q);
      pss2_q  <= pss1_q;
      pcs2_q  <= pcs1_q;
      ca2_q   <= ca1_q;

      pcca_q  <= dp_t'(tcc_q) * dp_t'(ca2_q);
      pss3_q  <= pss2_q;
      pcs3_q  <= pcs2_q;

      cosd3_q <= to_q30(pss3_q + pcca_q);
      pcs4_q  <= pcs3_q;

      csq_q   <= dp_t'(cosd3_q) * dp_t'(cosd3_q);
      cosd4_q <= cosd3_q;
      pcs5_q  <= pcs4_q;

      rad_q   <= D_ONE - turn_t'(csq_q);
      cosd5_q <= cosd4_q;
      pcs6_q  <= pcs5_q;
    end
  end

  // Sine of the distance.
  sq_t  sa_sq_q [SQ];
  q30_t cosd_dl_q [SQ];
  dp_t  pcs_dl_q [SQ];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sa_sq_q[0]   <= sq_step('{v: rad_q, r: '0}, 0);
      cosd_dl_q[0] <= cosd5_q;
      pcs_dl_q[0]  <= pcs6_q;
      for (int k = 1; k < SQ; k++) begin
        sa_sq_q[k]   <= sq_step(sa_sq_q[k-1], k);
        cosd_dl_q[k] <= cosd_dl_q[k-1];
        pcs_dl_q[k]  <= pcs_dl_q[k-1];
      end
    end
  end

  q30_t sind;
  q30_t cosd;
  dp_t  pcs;
  logic south_t0;
  logic flag_t0;

  assign sind     = signed'(sa_sq_q[SQ-1].r[31:0]);
  assign cosd     = cosd_dl_q[SQ-1];
  assign pcs      = pcs_dl_q[SQ-1];
  assign south_t0 = south_dl_q[DLY_S0-1];
  assign flag_t0  = (sind == '0);

  // Vectoring pre-rotation into the right half plane.
  function automatic logic [191:0] pre_rot(input q30_t y30, input q30_t x30);
    dp_t   x;
    dp_t   y;
    turn_t z;
    x = dp_t'(x30) <<< 30;
    y = dp_t'(y30) <<< 30;
    z = '0;
    if (x < 0) begin
      if (y >= 0) begin
        z = TURN_QUARTER;
        {x, y} = {y, -x};
      end else begin
        z = '0 - TURN_QUARTER;
        {x, y} = {-y, x};
      end
    end
    return {x, y, z};
  endfunction

  // Distance branch.
  dp_t   ax_q, ay_q, axo, ayo;
  turn_t az_q, azo;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      {ax_q, ay_q, az_q} <= pre_rot(sind, cosd);
    end
  end

  gcrb_cordic #(
    .STAGES    (CORDIC_STAGES),
    .VECTORING (1'b1)
  ) u_vec_dist (
    .clk_i (clk_i),
    .en_i  (adv),
    .x_i   (ax_q),
    .y_i   (ay_q),
    .z_i   (az_q),
    .x_o   (axo),
    .y_o   (ayo),
    .z_o   (azo)
  );

  turn_t dist_c;
  logic [ANGLE_BITS-1:0] dist_dl_q [DLY_A];

  always_comb begin
    dist_c = azo;
    if (azo > TURN_HALF) begin
      dist_c = (azo >= TURN_HALF + TURN_QUARTER) ? '0 : TURN_HALF;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dist_dl_q[0] <= to_ba(dist_c);
      for (int k = 1; k < DLY_A; k++) begin
        dist_dl_q[k] <= dist_dl_q[k-1];
      end
    end
  end

  logic [1:0] side_dl_q [DLY_S1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_dl_q[0] <= {south_t0, flag_t0};
      for (int k = 1; k < DLY_S1; k++) begin
        side_dl_q[k] <= side_dl_q[k-1];
      end
    end
  end

  // Bearing branch: restoring divider for cos(lat2) sin(dlon) / sin d.
  logic [61:0] rem_q [DV+1];
  logic [30:0] dvs_q [DV+1];
  logic [30:0] qb_q  [DV+1];
  logic        neg_q [DV+1];
  logic        ov_q  [DV+1];
  logic [60:0] num;
  logic [30:0] dvs;

  assign num = pcs[63] ? 61'(-pcs) : 61'(pcs);
  assign dvs = flag_t0 ? 31'd1 : sind[30:0];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rem_q[0] <= {1'b0, num};
      dvs_q[0] <= dvs;
      qb_q[0]  <= '0;
      neg_q[0] <= pcs[63];
      ov_q[0]  <= {1'b0, num} >= {dvs, 31'd0};
      for (int s = 1; s <= DV; s++) begin
        logic [61:0] dsh;
        dsh = 62'(dvs_q[s-1]) << (DV - s);
        dvs_q[s] <= dvs_q[s-1];
        neg_q[s] <= neg_q[s-1];
        ov_q[s]  <= ov_q[s-1];
        if (rem_q[s-1] >= dsh) begin
          rem_q[s] <= rem_q[s-1] - dsh;
          qb_q[s]  <= qb_q[s-1] | (31'd1 << (DV - s));
        end else begin
          rem_q[s] <= rem_q[s-1];
          qb_q[s]  <= qb_q[s-1];
        end
      end
    end
  end

  logic [30:0] qm;
  q30_t  q_q;
  dp_t   qq_q;
  turn_t xrad_q;
  q30_t  q_dl_q [DLY_Q];
  sq_t   xr_sq_q [SQ];

  always_comb begin
    qm = qb_q[DV];
    if (ov_q[DV] || qm > 31'h4000_0000) begin
      qm = 31'h4000_0000;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      q_q       <= neg_q[DV] ? -signed'({1'b0, qm}) : signed'({1'b0, qm});
      qq_q      <= dp_t'(q_q) * dp_t'(q_q);
      xrad_q    <= D_ONE - turn_t'(qq_q);
      q_dl_q[0] <= q_q;
      for (int k = 1; k < DLY_Q; k++) begin
        q_dl_q[k] <= q_dl_q[k-1];
      end
      xr_sq_q[0] <= sq_step('{v: xrad_q, r: '0}, 0);
      for (int k = 1; k < SQ; k++) begin
        xr_sq_q[k] <= sq_step(xr_sq_q[k-1], k);
      end
    end
  end

  dp_t   bx_q, by_q, bxo, byo;
  turn_t bz_q, bzo;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      {bx_q, by_q, bz_q} <= pre_rot(q_dl_q[DLY_Q-1], signed'(xr_sq_q[SQ-1].r[31:0]));
    end
  end

  gcrb_cordic #(
    .STAGES    (CORDIC_STAGES),
    .VECTORING (1'b1)
  ) u_vec_brg (
    .clk_i (clk_i),
    .en_i  (adv),
    .x_i   (bx_q),
    .y_i   (by_q),
    .z_i   (bz_q),
    .x_o   (bxo),
    .y_o   (byo),
    .z_o   (bzo)
  );

  // Output register.
  logic [1:0] side;
  turn_t      dir_c;
  logic [ANGLE_BITS-1:0] dist_q, brg_q;
  logic       undef_q;

  assign side  = side_dl_q[DLY_S1-1];
  assign dir_c = side[1] ? TURN_HALF - bzo : bzo;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dist_q  <= dist_dl_q[DLY_A-1];
      brg_q   <= side[0] ? '0 : to_ba(dir_c);
      undef_q <= side[0];
    end
  end

  assign out_o.valid             = vld_q[LAT-1];
  assign out_o.arc_distance      = dist_q;
  assign out_o.bearing           = brg_q;
  assign out_o.undefined_bearing = undef_q;

endmodule

`default_nettype wire

// File: sv/gcrb_checker.sv
// ============================================================================
// Great-circle range and bearing: port checker
// Concurrent assertions on the ports of the block, bound to the top level.
// ============================================================================
`default_nettype none
`include "great_circle_range_bearing_defines.svh"

module gcrb_checker #(
  parameter int ANGLE_BITS = 32
) (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_valid_i,
  input wire logic                  in_ready_i,
  input wire logic                  out_valid_i,
  input wire logic                  out_ready_i,
  input wire logic [ANGLE_BITS-1:0] arc_distance_i,
  input wire logic [ANGLE_BITS-1:0] bearing_i,
  input wire logic                  undefined_bearing_i
);

  localparam logic [ANGLE_BITS-1:0] HALF_BA = {1'b1, {(ANGLE_BITS-1){1'b0}}};

  `GCRB_ASSERT_IMP(a_ready_rule, clk_i, rst_ni, 1'b1, in_ready_i == (!out_valid_i || out_ready_i), "ready does not follow the output stall")
  `GCRB_ASSERT_IMP(a_undef_zero, clk_i, rst_ni, out_valid_i && undefined_bearing_i, bearing_i == '0, "undefined bearing is not zero")
  `GCRB_ASSERT_IMP(a_dist_range, clk_i, rst_ni, out_valid_i, arc_distance_i <= HALF_BA, "distance beyond half a turn")
  `GCRB_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(arc_distance_i) && $stable(bearing_i) && $stable(undefined_bearing_i), "stalled result changed")
  `GCRB_ASSERT_IMP(a_hs_known, clk_i, rst_ni, 1'b1, !$isunknown({in_valid_i, out_ready_i}), "handshake input is unknown")

endmodule

bind great_circle_range_bearing gcrb_checker #(
  .ANGLE_BITS (ANGLE_BITS)
) u_gcrb_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_i.valid),
  .in_ready_i          (in_i.ready),
  .out_valid_i         (out_o.valid),
  .out_ready_i         (out_o.ready),
  .arc_distance_i      (out_o.arc_distance),
  .bearing_i           (out_o.bearing),
  .undefined_bearing_i (out_o.undefined_bearing)
);

`default_nettype wire

// File: tb/sv/great_circle_range_bearing_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// Great-circle range and bearing: testbench
// Drives position pairs through the valid/ready channel with random idle
// bursts on both sides and compares every result with a bit-exact model of
// the CORDIC, square-root and divider arithmetic.
// ============================================================================
`default_nettype none

module great_circle_range_bearing_tb;
  import gcrb_pkg::*;

  localparam int  AB       = 32;
  localparam int  NSTAGES  = 30;
  localparam int  LATENCY  = 2 * NSTAGES + 109;
  localparam int  N_RANDOM = 630;
  localparam int  QUIET    = 100;
  localparam int  DRAIN_AT = 300;
  localparam longint QUARTER_BA = 64'sd1073741824;

  typedef struct packed {
    logic signed [AB-1:0] from_lon;
    logic signed [AB-1:0] from_lat;
    logic signed [AB-1:0] to_lon;
    logic signed [AB-1:0] to_lat;
  } pos_pair_t;

  typedef struct packed {
    logic [AB-1:0] arc;
    logic [AB-1:0] brg;
    logic          undef;
  } range_bearing_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  gcrb_in_if  #(.ANGLE_BITS(AB)) in_if ();
  gcrb_out_if #(.ANGLE_BITS(AB)) out_if ();

  great_circle_range_bearing #(
    .ANGLE_BITS   (AB),
    .CORDIC_STAGES(NSTAGES)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #5 clk_i = ~clk_i;

  turn_t          atan_tab[NSTAGES];
  dp_t            inv_gain;
  pos_pair_t      pending_q[$];
  range_bearing_t expected_q[$];
  int             n_total;
  int             n_sent;
  int             n_recv;
  int             n_mismatch;
  int             src_gap;
  int             snk_gap;

  function automatic turn_t q60_mul(input turn_t a, input turn_t b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  function automatic dp_t round_q30(input dp_t v);
    dp_t r;
    r = (v + (64'sd1 <<< 29)) >>> 30;
    if (r > Q_ONE) r = Q_ONE;
    if (r < -Q_ONE) r = -Q_ONE;
    return r;
  endfunction

  function automatic turn_t int_sqrt(input turn_t v);
    turn_t r;
    turn_t b;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  task automatic rotate_sincos(input turn_t theta, output dp_t s, output dp_t c);
    logic flip;
    dp_t  x;
    dp_t  y;
    dp_t  dx;
    dp_t  dy;
    flip = ((theta + TURN_QUARTER) >> 63) != 0;
    if (flip) theta = theta - TURN_HALF;
    x = inv_gain;
    y = '0;
    for (int i = 0; i < NSTAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (theta[63]) begin
        x = x + dx; y = y - dy; theta = theta + atan_tab[i];
      end else begin
        x = x - dx; y = y + dy; theta = theta - atan_tab[i];
      end
    end
    c = round_q30(x);
    s = round_q30(y);
    if (flip) begin
      c = -c;
      s = -s;
    end
  endtask

  function automatic turn_t vector_angle(input dp_t y30, input dp_t x30);
    dp_t   x;
    dp_t   y;
    dp_t   t;
    dp_t   dx;
    dp_t   dy;
    turn_t z;
    x = x30 * Q_ONE;
    y = y30 * Q_ONE;
    z = '0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = TURN_QUARTER;
      end else begin
        t = x; x = -y; y = t; z = 64'd0 - TURN_QUARTER;
      end
    end
    for (int i = 0; i < NSTAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx; y = y - dy; z = z + atan_tab[i];
      end else begin
        x = x - dx; y = y + dy; z = z - atan_tab[i];
      end
    end
    return z;
  endfunction

  function automatic logic [AB-1:0] turn_to_ba(input turn_t t);
    turn_t r;
    r = ((t >> (64 - AB - 1)) + 64'd1) >> 1;
    return r[AB-1:0];
  endfunction

  task automatic build_cordic_tables();
    turn_t        rad;
    turn_t        t;
    turn_t        p;
    turn_t        y;
    logic [127:0] w;
    int           e;
    p = D_ONE;
    for (int i = 0; i < NSTAGES; i++) begin
      rad = '0;
      if (i == 0) begin
        rad = PI_QUARTER_Q64;
      end else begin
        for (int k = 0; i * (2 * k + 1) < 64; k++) begin
          e = i * (2 * k + 1);
          t = (64'd1 << (64 - e)) / turn_t'(2 * k + 1);
          if (k % 2 == 1) rad = rad - t;
          else rad = rad + t;
        end
      end
      w = {64'd0, rad} * {64'd0, INV_TWO_PI_Q64};
      atan_tab[i] = w[127:64];
      if (2 * i < 64) p = p + (p >> (2 * i));
    end
    y = (D_ONE / 64'd10) * 64'd6;
    for (int i = 0; i < 8; i++) begin
      t = q60_mul(p, q60_mul(y, y));
      y = q60_mul(y, 64'd3 * D_ONE - t) >> 1;
    end
    inv_gain = dp_t'(y);
  endtask

  task automatic predict_range_bearing(input pos_pair_t a, output range_bearing_t r);
    turn_t lng1;
    turn_t lat1;
    turn_t lng2;
    turn_t lat2;
    turn_t arc_turn;
    turn_t dir;
    dp_t   sl1, cl1, sl2, cl2, sa, ca, cosd, sind, q, xr;
    lng1 = {a.from_lon, 32'd0};
    lat1 = {a.from_lat, 32'd0};
    lng2 = {a.to_lon, 32'd0};
    lat2 = {a.to_lat, 32'd0};
    rotate_sincos(lat1, sl1, cl1);
    rotate_sincos(lat2, sl2, cl2);
    rotate_sincos(lng2 - lng1, sa, ca);
    cosd = round_q30(sl2 * sl1 + round_q30(cl2 * cl1) * ca);
    sind = dp_t'(int_sqrt(turn_t'(dp_t'(D_ONE) - cosd * cosd)));
    arc_turn = vector_angle(sind, cosd);
    if (arc_turn > TURN_HALF) begin
      arc_turn = (arc_turn >= TURN_HALF + TURN_QUARTER) ? 64'd0 : TURN_HALF;
    end
    r.arc   = turn_to_ba(arc_turn);
    r.brg   = '0;
    r.undef = 1'b0;
    if (sind == 0) begin
      r.undef = 1'b1;
    end else begin
      q = (cl2 * sa) / sind;
      if (q > Q_ONE) q = Q_ONE;
      if (q < -Q_ONE) q = -Q_ONE;
      xr = dp_t'(int_sqrt(turn_t'(dp_t'(D_ONE) - q * q)));
      dir = vector_angle(q, xr);
      if ((lat2 ^ TURN_HALF) < (lat1 ^ TURN_HALF)) dir = TURN_HALF - dir;
      r.brg = turn_to_ba(dir);
    end
  endtask

  function automatic logic signed [AB-1:0] rand_lat();
    longint v;
    v = longint'($urandom_range(32'h8000_0000, 0)) - QUARTER_BA;
    return v[AB-1:0];
  endfunction

  task automatic add_pair(input logic [31:0] flo, input logic [31:0] fla,
                          input logic [31:0] tlo, input logic [31:0] tla);
    pos_pair_t p;
    p.from_lon = flo;
    p.from_lat = fla;
    p.to_lon   = tlo;
    p.to_lat   = tla;
    pending_q.push_back(p);
  endtask

  task automatic fill_stimulus();
    logic [31:0] flo, fla, tlo, tla;
    int          kind;
    add_pair(0, 0, 0, 0);
    add_pair(32'h1234_5678, 32'h0ABC_DEF0, 32'h1234_5678, 32'h0ABC_DEF0);
    add_pair(0, 0, 32'h8000_0000, 0);
    add_pair(0, 32'h4000_0000, 0, 32'hC000_0000);
    add_pair(32'h7FFF_FFFF, 32'h4000_0000, 32'h8000_0000, 32'hC000_0000);
    add_pair(32'h8000_0000, 32'hC000_0000, 32'h7FFF_FFFF, 32'h4000_0000);
    add_pair(32'h8000_0000, 0, 32'h7FFF_FFFF, 0);
    add_pair(0, 0, 1, 0);
    add_pair(0, 0, 0, 1);
    add_pair(0, 1, 0, 0);
    add_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
    add_pair(0, 0, 32'h4000_0000, 0);
    add_pair(0, 0, 32'hC000_0000, 0);
    add_pair(0, 0, 0, 32'h2000_0000);
    add_pair(0, 0, 0, 32'hE000_0000);
    add_pair(0, 32'h2000_0000, 32'h6000_0000, 32'hE000_0000);
    add_pair(32'h1000_0000, 32'h3FFF_FFFF, 32'h9000_0000, 32'h3FFF_FFFF);
    add_pair(0, 32'hC000_0001, 32'h1000_0000, 32'hC000_0000);
    add_pair(0, 32'h1000_0000, 32'h0000_0100, 32'h1000_0040);
    add_pair(0, 32'h1000_0000, 32'h8000_0000, 32'hF000_0000);
    for (int i = 0; i < N_RANDOM; i++) begin
      kind = $urandom_range(9, 0);
      flo = $urandom();
      fla = rand_lat();
      if (kind < 6) begin
        tlo = $urandom();
        tla = rand_lat();
      end else if (kind < 8) begin
        tlo = flo + 32'($signed($urandom_range(512, 0)) - 256);
        tla = fla + 32'($signed($urandom_range(512, 0)) - 256);
        if ($signed(tla) > 32'sh4000_0000 || $signed(tla) < -32'sh4000_0000) tla = fla;
      end else if (kind == 8) begin
        tlo = flo + 32'h8000_0000 + 32'($signed($urandom_range(64, 0)) - 32);
        tla = -fla;
      end else begin
        tlo = flo;
        tla = ($urandom_range(1, 0) != 0) ? 32'h4000_0000 : 32'hC000_0000;
      end
      add_pair(flo, fla, tlo, tla);
    end
    n_total = pending_q.size();
  endtask

  initial begin
    rst_ni                = 1'b0;
    in_if.valid           = 1'b0;
    in_if.from_longitude  = '0;
    in_if.from_latitude   = '0;
    in_if.to_longitude    = '0;
    in_if.to_latitude     = '0;
    out_if.ready          = 1'b0;
    n_sent                = 0;
    n_recv                = 0;
    n_mismatch            = 0;
    src_gap               = 0;
    snk_gap               = 0;
    build_cordic_tables();
    fill_stimulus();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_q.size() != 0 || in_if.valid || expected_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 20) @(posedge clk_i);
    if (n_mismatch == 0 && expected_q.size() == 0) begin
      $display("[great_circle_range_bearing] OK");
    end else begin
      $display("[great_circle_range_bearing] ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("[great_circle_range_bearing] ERROR");
    $finish;
  end

  always @(posedge clk_i) begin
    range_bearing_t exp_r;
    pos_pair_t      nxt;
    logic           v_next;
    if (rst_ni) begin
      v_next = in_if.valid;
      if (in_if.valid && in_if.ready) begin
        predict_range_bearing({in_if.from_longitude, in_if.from_latitude,
                               in_if.to_longitude, in_if.to_latitude}, exp_r);
        expected_q.push_back(exp_r);
        n_sent = n_sent + 1;
        v_next = 1'b0;
      end
      if (!v_next) begin
        if (src_gap > 0) begin
          src_gap = src_gap - 1;
        end else if (n_sent == DRAIN_AT && expected_q.size() != 0) begin
          v_next = 1'b0;
        end else if (n_sent < n_total - QUIET && $urandom_range(7, 0) == 0) begin
          src_gap = $urandom_range(11, 1) - 1;
        end else if (pending_q.size() != 0) begin
          nxt = pending_q.pop_front();
          in_if.from_longitude <= nxt.from_lon;
          in_if.from_latitude  <= nxt.from_lat;
          in_if.to_longitude   <= nxt.to_lon;
          in_if.to_latitude    <= nxt.to_lat;
          v_next = 1'b1;
        end
      end
      in_if.valid <= v_next;
    end
  end

  always @(posedge clk_i) begin
    range_bearing_t exp_r;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        n_recv = n_recv + 1;
        if (expected_q.size() == 0) begin
          n_mismatch = n_mismatch + 1;
          if (n_mismatch <= 10) $display("Unexpected result transaction %0d.", n_recv);
        end else begin
          exp_r = expected_q.pop_front();
          if (out_if.arc_distance !== exp_r.arc || out_if.bearing !== exp_r.brg ||
              out_if.undefined_bearing !== exp_r.undef) begin
            n_mismatch = n_mismatch + 1;
            if (n_mismatch <= 10) begin
              $display("Mismatch on result %0d: expected arc %h bearing %h flag %b, got %h %h %b.",
                       n_recv, exp_r.arc, exp_r.brg, exp_r.undef, out_if.arc_distance,
                       out_if.bearing, out_if.undefined_bearing);
            end
          end
        end
      end
      if (snk_gap > 0) begin
        snk_gap = snk_gap - 1;
        out_if.ready <= 1'b0;
      end else if (n_recv < n_total - QUIET && $urandom_range(7, 0) == 0) begin
        snk_gap = $urandom_range(11, 1) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: files.f
+incdir+sv
sv/gcrb_pkg.sv
sv/gcrb_in_if.sv
sv/gcrb_out_if.sv
sv/gcrb_cordic.sv
sv/great_circle_range_bearing.sv
sv/gcrb_checker.sv
tb/sv/great_circle_range_bearing_tb.sv
